// ----- src/mrvs_pkg.sv -----
`default_nettype none
package mrvs_pkg;

    localparam int MAX_VARS_DEF = 32;
    localparam int IDX_W        = 32;
    localparam int SZ_W         = 8;
    localparam int ID_W         = 6;
    localparam int STAT_W       = 3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REM = 2'd1;
    localparam logic [1:0] OP_QRY = 2'd2;
    localparam logic [1:0] OP_DEC = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_ID   = 3'd4;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ID_W-1:0]  var_id;
        logic [SZ_W-1:0]  domain_size;
        logic [IDX_W-1:0] instance_id;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              present;
        logic [4:0]        position;
        logic [ID_W-1:0]   out_var_id;
        logic [SZ_W-1:0]   var_state;
        logic [IDX_W-1:0]  multiplier;
        logic [SZ_W-1:0]   var_size;
        logic [5:0]        set_count;
        logic [IDX_W-1:0]  instance_total;
        logic              last;
    } result_t;

    // broadcast controls to every cell
    typedef struct packed {
        logic wr;
        logic shift;
        logic use_pos;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/mrvs_cell.sv -----
`default_nettype none
module mrvs_cell #(
    parameter int MAX_VARS = mrvs_pkg::MAX_VARS_DEF,
    parameter int CELL_IDX = 0,
    localparam int PW = $clog2(MAX_VARS),
    localparam int IW = mrvs_pkg::IDX_W,
    localparam int SW = mrvs_pkg::SZ_W,
    localparam int DW = mrvs_pkg::ID_W
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire mrvs_pkg::cell_ctrl_t ctrl,
    input  wire [PW-1:0]              wr_pos,
    input  wire [PW-1:0]              shift_pos,
    input  wire [PW-1:0]              key_pos,
    input  wire [DW-1:0]              key_id,
    input  wire [DW-1:0]              wr_var,
    input  wire [SW-1:0]              wr_size,
    input  wire [IW-1:0]              wr_weight,
    input  wire                       right_valid,
    input  wire [DW-1:0]              right_var,
    input  wire [SW-1:0]              right_size,
    input  wire                       left_tok,
    input  wire [IW-1:0]              left_weight,
    input  wire [SW-1:0]              left_size,
    output logic                      valid,
    output logic [DW-1:0]             ent_var,
    output logic [SW-1:0]             ent_size,
    output logic [IW-1:0]             ent_weight,
    output logic                      tok,
    output logic                      sel,
    output logic [PW-1:0]             bus_pos,
    output logic [DW-1:0]             bus_var,
    output logic [SW-1:0]             bus_size,
    output logic [IW-1:0]             bus_weight
);

    localparam logic [PW-1:0] MY_POS = PW'(CELL_IDX);

    logic              valid_reg;
    logic              tok_reg;
    logic [DW-1:0]     var_reg;
    logic [SW-1:0]     size_reg;
    logic [IW-1:0]     weight_reg;
    logic [IW+SW-1:0]  prod;
    logic              wr_here;
    logic              shift_here;

    assign wr_here    = ctrl.wr && (MY_POS == wr_pos);
    assign shift_here = ctrl.shift && (MY_POS >= shift_pos);
    assign prod       = {{SW{1'b0}}, left_weight} * {{IW{1'b0}}, left_size};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            // token marks the cell whose weight is already right after a remove
            tok_reg <= ctrl.shift ? (MY_POS == shift_pos) : left_tok;
            if (wr_here)
                valid_reg <= 1'b1;
            else if (shift_here)
                valid_reg <= right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            var_reg    <= wr_var;
            size_reg   <= wr_size;
            weight_reg <= wr_weight;
        end
        else if (shift_here)
        begin
            var_reg  <= right_var;
            size_reg <= right_size;
        end
        else if (left_tok)
            weight_reg <= prod[IW-1:0];
    end

    always_comb
    begin
        sel = valid_reg && (ctrl.use_pos ? (MY_POS == key_pos) : (var_reg == key_id));
    end

    assign valid      = valid_reg;
    assign ent_var    = var_reg;
    assign ent_size   = size_reg;
    assign ent_weight = weight_reg;
    assign tok        = tok_reg;
    assign bus_pos    = sel ? MY_POS : '0;
    assign bus_var    = sel ? var_reg : '0;
    assign bus_size   = sel ? size_reg : '0;
    assign bus_weight = sel ? weight_reg : '0;

endmodule
`default_nettype wire

// ----- src/mrvs_div.sv -----
`default_nettype none
module mrvs_div #(
    parameter int W = mrvs_pkg::IDX_W,
    localparam int CW = $clog2(W + 1)
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire [W-1:0]  num,
    input  wire [W-1:0]  den,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W:0]    sh;
    logic          ge;

    assign sh = {rem_reg, quo_reg[W-1]};
    assign ge = sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(W);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? W'(sh - {1'b0, den_reg}) : sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ----- src/mixed_radix_variable_set_core.sv -----
`default_nettype none
// Bad id and decode-all of an empty set are answered straight from idle; add, refused add,
// absent remove or absent query go through look and decide; remove then walks a fix-up token
// through the cells. Query: two passes of the bit-serial divider, index / weight then
// quotient mod size. Decode-all repeats lookup and both passes for each member in turn.
// One command at a time; busy is high until its last word is strobed. Results
// cannot be stalled. Reset empties the set (count 0, total 1); entries need no clearing.
module mixed_radix_variable_set_core #(
    parameter int MAX_VARS = mrvs_pkg::MAX_VARS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire mrvs_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output mrvs_pkg::result_t      result
);

    localparam int PW = $clog2(MAX_VARS);
    localparam int CW = $clog2(MAX_VARS + 1);
    localparam int IW = mrvs_pkg::IDX_W;
    localparam int SW = mrvs_pkg::SZ_W;
    localparam int DW = mrvs_pkg::ID_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FIX    = 3'd3;
    localparam logic [2:0] S_RTOT   = 3'd4;
    localparam logic [2:0] S_DIV1   = 3'd5;
    localparam logic [2:0] S_DIV2   = 3'd6;

    logic [2:0]          state_reg;
    logic [CW-1:0]       count_reg;
    logic [IW-1:0]       total_reg;
    logic [CW-1:0]       fix_cnt_reg;
    mrvs_pkg::cmd_t      cmd_reg;
    logic [DW-1:0]       key_id_reg;
    logic [PW-1:0]       key_pos_reg;
    logic                use_pos_reg;
    logic                hit_reg;
    logic [PW-1:0]       h_pos_reg;
    logic [DW-1:0]       h_var_reg;
    logic [SW-1:0]       h_size_reg;
    logic [IW-1:0]       h_weight_reg;
    logic [IW+SW-1:0]    prod_reg;
    logic                div_start_reg;
    logic [IW-1:0]       div_num_reg;
    logic [IW-1:0]       div_den_reg;
    logic                done_reg;
    mrvs_pkg::result_t   res_reg;

    mrvs_pkg::cell_ctrl_t ctrl;
    logic                 add_ok;
    logic                 id_ok;
    logic [IW+SW-1:0]     rtot_prod;
    logic                 div_done;
    logic [IW-1:0]        div_quot;
    logic [IW-1:0]        div_rem;

    // cell chain wiring
    logic          c_valid  [MAX_VARS];
    logic [DW-1:0] c_var    [MAX_VARS];
    logic [SW-1:0] c_size   [MAX_VARS];
    logic [IW-1:0] c_weight [MAX_VARS];
    logic          c_tok    [MAX_VARS];
    logic          c_sel    [MAX_VARS];
    logic [PW-1:0] b_pos    [MAX_VARS];
    logic [DW-1:0] b_var    [MAX_VARS];
    logic [SW-1:0] b_size   [MAX_VARS];
    logic [IW-1:0] b_weight [MAX_VARS];

    logic          bus_hit;
    logic [PW-1:0] bus_pos;
    logic [DW-1:0] bus_var;
    logic [SW-1:0] bus_size;
    logic [IW-1:0] bus_weight;

    function automatic mrvs_pkg::result_t mk_res(
        input logic [2:0]    st,
        input logic          pres,
        input logic [PW-1:0] pos,
        input logic [DW-1:0] vid,
        input logic [SW-1:0] vstate,
        input logic [IW-1:0] mult,
        input logic [SW-1:0] vsize,
        input logic [CW-1:0] cnt,
        input logic [IW-1:0] tot,
        input logic          lst
    );
        mrvs_pkg::result_t r;
        r.status         = st;
        r.present        = pres;
        r.position       = 5'(pos);
        r.out_var_id     = vid;
        r.var_state      = vstate;
        r.multiplier     = mult;
        r.var_size       = vsize;
        r.set_count      = 6'(cnt);
        r.instance_total = tot;
        r.last           = lst;
        return r;
    endfunction

    // add is legal once present, zero size and overflow are ruled out
    assign add_ok = !hit_reg && (cmd_reg.domain_size != '0)
                    && (count_reg < CW'(MAX_VARS)) && (prod_reg[IW+SW-1:IW] == '0);
    assign id_ok  = (cmd.var_id != '0) && ({1'b0, cmd.var_id} <= (DW+1)'(MAX_VARS));

    always_comb
    begin
        ctrl.use_pos = use_pos_reg;
        ctrl.wr      = (state_reg == S_DECIDE) && (cmd_reg.operation == mrvs_pkg::OP_ADD)
                       && add_ok;
        ctrl.shift   = (state_reg == S_DECIDE) && (cmd_reg.operation == mrvs_pkg::OP_REM)
                       && hit_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VARS; gi++)
        begin : g_cell
            logic          r_valid;
            logic [DW-1:0] r_var;
            logic [SW-1:0] r_size;
            logic          l_tok;
            logic [IW-1:0] l_weight;
            logic [SW-1:0] l_size;

            if (gi == MAX_VARS - 1)
            begin : g_end
                assign r_valid = 1'b0;
                assign r_var   = '0;
                assign r_size  = '0;
            end
            else
            begin : g_mid
                assign r_valid = c_valid[gi+1];
                assign r_var   = c_var[gi+1];
                assign r_size  = c_size[gi+1];
            end

            if (gi == 0)
            begin : g_head
                assign l_tok    = 1'b0;
                assign l_weight = '0;
                assign l_size   = '0;
            end
            else
            begin : g_body
                assign l_tok    = c_tok[gi-1];
                assign l_weight = c_weight[gi-1];
                assign l_size   = c_size[gi-1];
            end

            mrvs_cell #(
                .MAX_VARS (MAX_VARS),
                .CELL_IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .wr_pos      (count_reg[PW-1:0]),
                .shift_pos   (h_pos_reg),
                .key_pos     (key_pos_reg),
                .key_id      (key_id_reg),
                .wr_var      (cmd_reg.var_id),
                .wr_size     (cmd_reg.domain_size),
                .wr_weight   (total_reg),
                .right_valid (r_valid),
                .right_var   (r_var),
                .right_size  (r_size),
                .left_tok    (l_tok),
                .left_weight (l_weight),
                .left_size   (l_size),
                .valid       (c_valid[gi]),
                .ent_var     (c_var[gi]),
                .ent_size    (c_size[gi]),
                .ent_weight  (c_weight[gi]),
                .tok         (c_tok[gi]),
                .sel         (c_sel[gi]),
                .bus_pos     (b_pos[gi]),
                .bus_var     (b_var[gi]),
                .bus_size    (b_size[gi]),
                .bus_weight  (b_weight[gi])
            );
        end
    endgenerate

    // at most one cell selects, so an OR gathers its fields
    always_comb
    begin
        bus_hit    = 1'b0;
        bus_pos    = '0;
        bus_var    = '0;
        bus_size   = '0;
        bus_weight = '0;
        for (int i = 0; i < MAX_VARS; i++)
        begin
            bus_hit    = bus_hit | c_sel[i];
            bus_pos    = bus_pos | b_pos[i];
            bus_var    = bus_var | b_var[i];
            bus_size   = bus_size | b_size[i];
            bus_weight = bus_weight | b_weight[i];
        end
    end

    assign rtot_prod = {{SW{1'b0}}, bus_weight} * {{IW{1'b0}}, bus_size};

    mrvs_div #(
        .W (IW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= IW'(1);
            fix_cnt_reg   <= '0;
            key_id_reg    <= '0;
            key_pos_reg   <= '0;
            use_pos_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        key_id_reg  <= cmd.var_id;
                        key_pos_reg <= '0;
                        use_pos_reg <= (cmd.operation == mrvs_pkg::OP_DEC);
                        if (cmd.operation == mrvs_pkg::OP_DEC && count_reg == '0)
                        begin
                            done_reg <= 1'b1;
                            res_reg  <= mk_res(mrvs_pkg::ST_ABSENT, 1'b0, '0, '0, '0, '0,
                                               '0, count_reg, total_reg, 1'b1);
                        end
                        else if (cmd.operation != mrvs_pkg::OP_DEC && !id_ok)
                        begin
                            done_reg <= 1'b1;
                            res_reg  <= mk_res(mrvs_pkg::ST_BAD_ID, 1'b0, '0, cmd.var_id,
                                               '0, '0, '0, count_reg, total_reg, 1'b1);
                        end
                        else
                            state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_IDLE;
                    case (cmd_reg.operation)
                        mrvs_pkg::OP_ADD:
                        begin
                            done_reg <= 1'b1;
                            if (hit_reg)
                                res_reg <= mk_res(mrvs_pkg::ST_PRESENT, 1'b1, h_pos_reg,
                                                  cmd_reg.var_id, '0, h_weight_reg,
                                                  h_size_reg, count_reg, total_reg, 1'b1);
                            else if (cmd_reg.domain_size == '0)
                                res_reg <= mk_res(mrvs_pkg::ST_BAD_ID, 1'b0, '0,
                                                  cmd_reg.var_id, '0, '0, '0, count_reg,
                                                  total_reg, 1'b1);
                            else if (!add_ok)
                                res_reg <= mk_res(mrvs_pkg::ST_OVERFLOW, 1'b0, '0,
                                                  cmd_reg.var_id, '0, '0, '0, count_reg,
                                                  total_reg, 1'b1);
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                                total_reg <= prod_reg[IW-1:0];
                                res_reg   <= mk_res(mrvs_pkg::ST_OK, 1'b1,
                                                    count_reg[PW-1:0], cmd_reg.var_id, '0,
                                                    total_reg, cmd_reg.domain_size,
                                                    count_reg + 1'b1, prod_reg[IW-1:0],
                                                    1'b1);
                            end
                        end
                        mrvs_pkg::OP_REM:
                        begin
                            if (hit_reg)
                            begin
                                fix_cnt_reg <= CW'(MAX_VARS);
                                state_reg   <= S_FIX;
                            end
                            else
                            begin
                                done_reg <= 1'b1;
                                res_reg  <= mk_res(mrvs_pkg::ST_ABSENT, 1'b0, '0,
                                                   cmd_reg.var_id, '0, '0, '0, count_reg,
                                                   total_reg, 1'b1);
                            end
                        end
                        default:
                        begin
                            // query or one member of decode-all
                            if (hit_reg)
                            begin
                                div_num_reg   <= cmd_reg.instance_id;
                                div_den_reg   <= h_weight_reg;
                                div_start_reg <= 1'b1;
                                state_reg     <= S_DIV1;
                            end
                            else
                            begin
                                done_reg <= 1'b1;
                                res_reg  <= mk_res(mrvs_pkg::ST_ABSENT, 1'b0, '0,
                                                   cmd_reg.var_id, '0, '0, '0, count_reg,
                                                   total_reg, 1'b1);
                            end
                        end
                    endcase
                end
                S_FIX:
                begin
                    fix_cnt_reg <= fix_cnt_reg - 1'b1;
                    if (fix_cnt_reg == CW'(1))
                    begin
                        key_pos_reg <= PW'(count_reg - CW'(2));
                        use_pos_reg <= 1'b1;
                        state_reg   <= S_RTOT;
                    end
                end
                S_RTOT:
                begin
                    // new total is weight times size of the new last entry, or 1 once the set is empty
                    count_reg <= count_reg - 1'b1;
                    total_reg <= (count_reg == CW'(1)) ? IW'(1) : rtot_prod[IW-1:0];
                    done_reg  <= 1'b1;
                    res_reg   <= mk_res(mrvs_pkg::ST_OK, 1'b0, '0, cmd_reg.var_id, '0, '0,
                                        '0, count_reg - 1'b1,
                                        (count_reg == CW'(1)) ? IW'(1) : rtot_prod[IW-1:0],
                                        1'b1);
                    state_reg <= S_IDLE;
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        div_num_reg   <= div_quot;
                        div_den_reg   <= {{(IW-SW){1'b0}}, h_size_reg};
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        done_reg <= 1'b1;
                        if (cmd_reg.operation == mrvs_pkg::OP_DEC)
                        begin
                            res_reg <= mk_res(mrvs_pkg::ST_OK, 1'b1, h_pos_reg, h_var_reg,
                                              div_rem[SW-1:0], h_weight_reg, h_size_reg,
                                              count_reg, total_reg,
                                              ({1'b0, h_pos_reg} == (PW+1)'(count_reg - 1'b1)));
                            if ({1'b0, h_pos_reg} == (PW+1)'(count_reg - 1'b1))
                                state_reg <= S_IDLE;
                            else
                            begin
                                key_pos_reg <= h_pos_reg + 1'b1;
                                state_reg   <= S_LOOK;
                            end
                        end
                        else
                        begin
                            res_reg   <= mk_res(mrvs_pkg::ST_OK, 1'b1, h_pos_reg,
                                                cmd_reg.var_id, div_rem[SW-1:0],
                                                h_weight_reg, h_size_reg, count_reg,
                                                total_reg, 1'b1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // command and lookup payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
        if (state_reg == S_LOOK)
        begin
            hit_reg      <= bus_hit;
            h_pos_reg    <= bus_pos;
            h_var_reg    <= bus_var;
            h_size_reg   <= bus_size;
            h_weight_reg <= bus_weight;
            prod_reg     <= {{SW{1'b0}}, total_reg} * {{IW{1'b0}}, cmd_reg.domain_size};
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_VARS);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("member count past depth");

    property p_total_nonzero;
        @(posedge clk) disable iff (!rst_n) total_reg != '0;
    endproperty
    a_total_nonzero: assert property (p_total_nonzero) else $error("joint total is zero");

    property p_strobe_cause;
        @(posedge clk) disable iff (!rst_n) done |-> ($past(busy) || $past(start));
    endproperty
    a_strobe_cause: assert property (p_strobe_cause) else $error("word strobed while idle");

    property p_div_only_in_query;
        @(posedge clk) disable iff (!rst_n)
            div_start_reg |-> (state_reg == S_DIV1 || state_reg == S_DIV2);
    endproperty
    a_div_only_in_query: assert property (p_div_only_in_query) else $error("stray divide");

endmodule
`default_nettype wire
